@@ hw/rtl/kfei_pkg.sv @@
// shared types, constants and sine table builder for the keyframe easing interpolator
package kfei_pkg;

  localparam int KEYS_PER_TRACK_DEF = 16;
  localparam int TRACKS             = 3;
  localparam int SINE_TABLE_SIZE    = 256;
  localparam int IN_TDATA_W         = 168;
  localparam int OUT_TDATA_W        = 96;
  localparam int CFG_ADDR_W         = 2;
  localparam int CFG_DATA_W         = 16;
  localparam int CNT_W              = 5;
  localparam int FRAC_STEPS         = 16;

  localparam logic [15:0] SPEED_RESET = 16'd256;
  localparam logic [16:0] ONE_Q16     = 17'h10000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SPEED    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_POS_CNT  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ROT_CNT  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SCL_CNT  = 2'd3;

  // item kinds
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_TICK   = 2'd1;
  localparam logic [1:0] ACT_TOGGLE = 2'd2;

  // easing modes
  localparam logic [1:0] EASE_LINEAR = 2'd0;
  localparam logic [1:0] EASE_IN     = 2'd1;
  localparam logic [1:0] EASE_OUT    = 2'd2;
  localparam logic [1:0] EASE_INOUT  = 2'd3;

  typedef struct packed {
    logic [31:0] delta_time;
    logic [1:0]  easing;
    logic [31:0] key_z;
    logic [31:0] key_y;
    logic [31:0] key_x;
    logic [31:0] key_time;
    logic [3:0]  key_index;
    logic [1:0]  track;
  } in_data_t;

  typedef struct packed {
    logic [1:0]  easing;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
    logic [31:0] t;
  } key_t;

  typedef enum logic [3:0] {
    S_IDLE, S_TIME, S_TRK, S_SRD, S_SCHK, S_CAPS, S_CAPE, S_DIV,
    S_EASE1, S_EASE2, S_BMUL, S_BOUT, S_EMIT
  } state_t;

  typedef struct packed {
    logic load_wr;
    logic mul_time;
    logic add_time;
    logic trk_first;
    logic trk_next;
    logic srch_init;
    logic srch_step;
    logic rd_pick;
    logic cap_s;
    logic hold;
    logic cap_e;
    logic div_step;
    logic ease1;
    logic ease2;
    logic blend_mul;
    logic blend_out;
  } cmd_t;

  typedef struct packed {
    logic trk_empty;
    logic trk_last;
    logic out_last;
    logic e_lt_cnt;
    logic key_le_time;
    logic at_end;
    logic div_done;
    logic comp_last;
  } sts_t;

  typedef logic [16:0] sine_tab_t [0:SINE_TABLE_SIZE];

  // quarter-wave sine in q1.16 from a nine-term series in q2.30
  function automatic sine_tab_t build_sine_table();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] e;
    for (int i = 0; i <= SINE_TABLE_SIZE; i++) begin
      x    = HALF_PI_Q30 * 64'(i) / SINE_TABLE_SIZE;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int k = 0; k < 8; k++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[k];
        if ((k % 2) == 0) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      e = (sum + 64'd8192) >> 14;
      tab[i] = (e > 64'(ONE_Q16)) ? ONE_Q16 : e[16:0];
    end
    return tab;
  endfunction

endpackage

@@ hw/rtl/kfei_ram.sv @@
// generic single write, single read ram with registered read data
module kfei_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/kfei_ctrl.sv @@
// controller state machine sequencing key search, division, easing and blend
module kfei_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic [1:0]        in_action,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  kfei_pkg::sts_t    sts,
  output kfei_pkg::cmd_t    cmd
);
  import kfei_pkg::*;

  state_t state_r, state_nxt;
  logic   playing_r, playing_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      playing_r <= 1'b1;
    end else begin
      state_r   <= state_nxt;
      playing_r <= playing_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    playing_nxt = playing_r;
    cmd         = '0;
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_action)
            ACT_LOAD:   cmd.load_wr = 1'b1;
            ACT_TOGGLE: playing_nxt = !playing_r;
            ACT_TICK: begin
              if (playing_r) begin
                cmd.mul_time = 1'b1;
                state_nxt    = S_TIME;
              end
            end
            default: ;
          endcase
        end
      end
      S_TIME: begin
        cmd.add_time  = 1'b1;
        cmd.trk_first = 1'b1;
        state_nxt     = S_TRK;
      end
      S_TRK: begin
        if (sts.trk_empty) begin
          if (sts.trk_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.trk_next = 1'b1;
          end
        end else begin
          cmd.srch_init = 1'b1;
          state_nxt     = S_SRD;
        end
      end
      S_SRD: begin
        if (sts.e_lt_cnt) begin
          state_nxt = S_SCHK;
        end else begin
          cmd.rd_pick = 1'b1;
          state_nxt   = S_CAPS;
        end
      end
      S_SCHK: begin
        if (sts.key_le_time) begin
          cmd.srch_step = 1'b1;
          state_nxt     = S_SRD;
        end else begin
          cmd.rd_pick = 1'b1;
          state_nxt   = S_CAPS;
        end
      end
      S_CAPS: begin
        cmd.cap_s = 1'b1;
        if (sts.at_end) begin
          cmd.hold  = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_CAPE;
        end
      end
      S_CAPE: begin
        cmd.cap_e = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_EASE1;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_EASE1: begin
        cmd.ease1 = 1'b1;
        state_nxt = S_EASE2;
      end
      S_EASE2: begin
        cmd.ease2 = 1'b1;
        state_nxt = S_BMUL;
      end
      S_BMUL: begin
        cmd.blend_mul = 1'b1;
        state_nxt     = S_BOUT;
      end
      S_BOUT: begin
        cmd.blend_out = 1'b1;
        state_nxt     = sts.comp_last ? S_EMIT : S_BMUL;
      end
      S_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (sts.out_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.trk_next = 1'b1;
            state_nxt    = S_TRK;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/kfei_datapath.sv @@
// datapath: config registers, key store, time update, divider, sine easing, blend
module kfei_datapath #(
  parameter int KEYS_PER_TRACK = kfei_pkg::KEYS_PER_TRACK_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [kfei_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [kfei_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
  input  kfei_pkg::in_data_t                  in_data,
  input  kfei_pkg::cmd_t                      cmd,
  output kfei_pkg::sts_t                      sts,
  output logic [kfei_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [1:0]                          out_tuser
);
  import kfei_pkg::*;

  localparam int AW = $clog2(TRACKS * KEYS_PER_TRACK);
  localparam int IW = $clog2(SINE_TABLE_SIZE + 1);
  localparam int PW = 16 + IW;
  localparam logic [AW-1:0] BASE1 = AW'(KEYS_PER_TRACK);
  localparam logic [AW-1:0] BASE2 = AW'(2 * KEYS_PER_TRACK);
  localparam sine_tab_t SINE_TAB = build_sine_table();

  // config and time
  logic [15:0]       speed_r;
  logic [CNT_W-1:0]  cnt_r [TRACKS];
  logic [31:0]       anim_r;
  logic [47:0]       tprod_r;

  // track walk
  logic [1:0]        tr_r;
  logic [CNT_W-1:0]  e_r;
  logic [CNT_W-1:0]  cnt_eff;
  logic [AW-1:0]     base;
  logic [AW-1:0]     wr_base;
  logic [AW-1:0]     rd_addr;
  logic [CNT_W-1:0]  s_idx;
  logic              wr_ok;
  key_t              rd_key;

  // segment
  logic [31:0]       ts_r;
  logic [31:0]       span_r;
  logic [31:0]       rem_r;
  logic [15:0]       quot_r;
  logic [4:0]        div_cnt_r;
  logic [1:0]        mode_r;
  logic [31:0]       vs_r [TRACKS];
  logic [31:0]       ve_r [TRACKS];

  // easing
  logic [16:0]       arg;
  logic [PW-1:0]     pos;
  logic [IW-1:0]     tidx;
  logic [16:0]       lo;
  logic [16:0]       hi;
  logic [16:0]       lo_r;
  logic [16:0]       dh_r;
  logic [15:0]       frac_r;
  logic [32:0]       qprod;
  logic [16:0]       q;
  logic [17:0]       half;
  logic [16:0]       r_nxt;
  logic [16:0]       r_r;

  // blend
  logic [1:0]        comp_r;
  logic signed [32:0] diff;
  logic signed [50:0] bprod;
  logic signed [50:0] bprod_r;
  logic signed [50:0] bsum;
  logic [31:0]       out_v_r [TRACKS];

  logic [32:0]       rem2;
  logic [40:0]       tsum;

  // count clamp to the track depth
  always_comb begin
    cnt_eff = cnt_r[tr_r];
    if (32'(cnt_r[tr_r]) > KEYS_PER_TRACK) begin
      cnt_eff = CNT_W'(KEYS_PER_TRACK);
    end
  end

  always_comb begin
    case (tr_r)
      2'd0:    base = '0;
      2'd1:    base = BASE1;
      default: base = BASE2;
    endcase
    case (in_data.track)
      2'd0:    wr_base = '0;
      2'd1:    wr_base = BASE1;
      default: wr_base = BASE2;
    endcase
    wr_ok   = (32'(in_data.track) < TRACKS) && (32'(in_data.key_index) < KEYS_PER_TRACK);
    s_idx   = (e_r == '0) ? '0 : e_r - 1'b1;
    rd_addr = cmd.rd_pick ? base + AW'(s_idx) : base + AW'(e_r);
  end

  kfei_ram #(
    .WIDTH ($bits(key_t)),
    .DEPTH (TRACKS * KEYS_PER_TRACK),
    .ADDR_W(AW)
  ) u_keys (
    .clk    (clk),
    .wr_en  (cmd.load_wr && wr_ok),
    .wr_addr(wr_base + AW'(in_data.key_index)),
    .wr_data({in_data.easing, in_data.key_z, in_data.key_y, in_data.key_x,
              in_data.key_time}),
    .rd_addr(rd_addr),
    .rd_data(rd_key)
  );

  // status
  always_comb begin
    sts.trk_empty   = (cnt_r[tr_r] == '0);
    sts.trk_last    = (tr_r == 2'd2);
    case (tr_r)
      2'd0:    sts.out_last = (cnt_r[1] == '0) && (cnt_r[2] == '0);
      2'd1:    sts.out_last = (cnt_r[2] == '0);
      default: sts.out_last = 1'b1;
    endcase
    sts.e_lt_cnt    = (e_r < cnt_eff);
    sts.key_le_time = (rd_key.t <= anim_r);
    sts.at_end      = (e_r == '0) || (e_r == cnt_eff);
    sts.div_done    = (div_cnt_r == '0);
    sts.comp_last   = (comp_r == 2'd2);
  end

  assign tsum = {9'd0, anim_r} + {1'b0, tprod_r[47:8]};
  assign rem2 = {rem_r, 1'b0};

  // sine lookup with linear interpolation between entries
  always_comb begin
    case (mode_r)
      EASE_IN:  arg = ONE_Q16 - {1'b0, quot_r};
      EASE_OUT: arg = {1'b0, quot_r};
      EASE_INOUT: begin
        if (!quot_r[15]) begin
          arg = ONE_Q16 - {quot_r, 1'b0};
        end else begin
          arg = {quot_r, 1'b0} - ONE_Q16;
        end
      end
      default:  arg = {1'b0, quot_r};
    endcase
    pos  = PW'(arg) * PW'(SINE_TABLE_SIZE);
    tidx = pos[PW-1:16];
    if (32'(tidx) >= SINE_TABLE_SIZE) begin
      lo = SINE_TAB[SINE_TABLE_SIZE];
      hi = SINE_TAB[SINE_TABLE_SIZE];
    end else begin
      lo = SINE_TAB[tidx];
      hi = SINE_TAB[tidx + 1'b1];
    end
    if (hi < lo) begin
      hi = lo;
    end
  end

  always_comb begin
    qprod = {16'd0, dh_r} * {17'd0, frac_r};
    q     = lo_r + qprod[32:16];
    half  = '0;
    case (mode_r)
      EASE_IN:  r_nxt = ONE_Q16 - q;
      EASE_OUT: r_nxt = q;
      EASE_INOUT: begin
        if (!quot_r[15]) begin
          half = {1'b0, ONE_Q16 - q};
        end else begin
          half = {1'b0, ONE_Q16} + {1'b0, q};
        end
        r_nxt = half[17:1];
      end
      default:  r_nxt = {1'b0, quot_r};
    endcase
  end

  assign diff  = $signed({ve_r[comp_r][31], ve_r[comp_r]})
               - $signed({vs_r[comp_r][31], vs_r[comp_r]});
  assign bprod = 51'(diff) * 51'($signed({1'b0, r_r}));
  assign bsum  = bprod_r + 51'sd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= SPEED_RESET;
      for (int i = 0; i < TRACKS; i++) begin
        cnt_r[i] <= '0;
      end
      anim_r    <= '0;
      tr_r      <= '0;
      e_r       <= '0;
      div_cnt_r <= '0;
      comp_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_SPEED:   speed_r  <= cfg_wr_data;
          REG_POS_CNT: cnt_r[0] <= cfg_wr_data[CNT_W-1:0];
          REG_ROT_CNT: cnt_r[1] <= cfg_wr_data[CNT_W-1:0];
          REG_SCL_CNT: cnt_r[2] <= cfg_wr_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.add_time) begin
        anim_r <= (tsum[40:32] != '0) ? 32'hFFFF_FFFF : tsum[31:0];
      end
      if (cmd.trk_first) begin
        tr_r <= '0;
      end else if (cmd.trk_next) begin
        tr_r <= tr_r + 1'b1;
      end
      if (cmd.srch_init) begin
        e_r <= '0;
      end else if (cmd.srch_step) begin
        e_r <= e_r + 1'b1;
      end
      if (cmd.cap_e) begin
        div_cnt_r <= 5'(FRAC_STEPS);
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r - 1'b1;
      end
      if (cmd.ease2) begin
        comp_r <= '0;
      end else if (cmd.blend_out) begin
        comp_r <= comp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_time) begin
      tprod_r <= {16'd0, in_data.delta_time} * {32'd0, speed_r};
    end
    if (cmd.cap_s) begin
      ts_r     <= rd_key.t;
      vs_r[0]  <= rd_key.x;
      vs_r[1]  <= rd_key.y;
      vs_r[2]  <= rd_key.z;
    end
    if (cmd.hold) begin
      out_v_r[0] <= rd_key.x;
      out_v_r[1] <= rd_key.y;
      out_v_r[2] <= rd_key.z;
    end
    if (cmd.cap_e) begin
      span_r  <= rd_key.t - ts_r;
      rem_r   <= anim_r - ts_r;
      quot_r  <= '0;
      mode_r  <= rd_key.easing;
      ve_r[0] <= rd_key.x;
      ve_r[1] <= rd_key.y;
      ve_r[2] <= rd_key.z;
    end
    // restoring division, one quotient bit a cycle
    if (cmd.div_step) begin
      if (rem2 >= {1'b0, span_r}) begin
        rem_r  <= 32'(rem2 - {1'b0, span_r});
        quot_r <= {quot_r[14:0], 1'b1};
      end else begin
        rem_r  <= rem2[31:0];
        quot_r <= {quot_r[14:0], 1'b0};
      end
    end
    if (cmd.ease1) begin
      lo_r   <= lo;
      dh_r   <= hi - lo;
      frac_r <= pos[15:0];
    end
    if (cmd.ease2) begin
      r_r <= r_nxt;
    end
    if (cmd.blend_mul) begin
      bprod_r <= bprod;
    end
    if (cmd.blend_out) begin
      out_v_r[comp_r] <= vs_r[comp_r] + 32'(bsum >>> 16);
    end
  end

  assign out_tdata = {out_v_r[2], out_v_r[1], out_v_r[0]};
  assign out_tuser = tr_r;

endmodule

@@ hw/rtl/keyframe_easing_interpolator_core.sv @@
// top level of the keyframe easing interpolator: ports, controller and datapath
// Three keyframe tracks (position, rotation, scale) of KEYS_PER_TRACK keys each, held
// in one key ram. A load transfer writes one key, a toggle transfer flips play and
// pause (playing after reset), and a tick transfer, while playing, advances the
// animation time by delta_time * speed (saturating) and then gives one result per
// non-empty track, in track order, tlast on the final one. Items are handled one at
// a time: a load or toggle is handled in the idle state; a tick walks the tracks,
// skipping empty ones, and per non-empty track runs the linear key scan through the
// single ram read port and, when interpolating, the 16-step restoring divider, the
// sine easing and the shared blend multiplier used once per component; each result
// then waits for its output transfer. No clearing pass: keys must be loaded before
// a tick can reach them.
module keyframe_easing_interpolator_core #(
  parameter int KEYS_PER_TRACK = kfei_pkg::KEYS_PER_TRACK_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata, low bit up: track[1:0], key_index[5:2], key_time[37:6], key_x[69:38],
  // key_y[101:70], key_z[133:102], easing[135:134], delta_time[167:136]
  input  logic [kfei_pkg::IN_TDATA_W-1:0]   in_tdata,
  // tuser: action[1:0]
  input  logic [1:0]                        in_tuser,
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata, low bit up: out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [kfei_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // tuser: out_track[1:0]
  output logic [1:0]                        out_tuser,
  output logic                              out_tlast,
  // configuration writes
  input  logic                              cfg_wr_en,
  input  logic [kfei_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [kfei_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
  import kfei_pkg::*;

  cmd_t     cmd;
  sts_t     sts;
  in_data_t in_data;

  assign in_data   = in_tdata;
  // last result of a tick when no later track holds keys
  assign out_tlast = sts.out_last;

  kfei_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tuser),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kfei_datapath #(
    .KEYS_PER_TRACK(KEYS_PER_TRACK)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wr_data(cfg_wr_data),
    .in_data    (in_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTH
  // no new item is taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while result pending");

  // the final result of a tick returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("not idle after final result");

  // after a load or toggle the block is ready again in the following cycle
  a_quick_items: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == ACT_LOAD || in_tuser == ACT_TOGGLE))
      |=> in_tready)
    else $error("load or toggle did not return to idle");

  // no divide step, end-key capture or blend output runs while the block is idle
  a_idle_cmds: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(cmd.div_step || cmd.blend_out || cmd.cap_e))
    else $error("datapath busy while idle");
`endif

endmodule
